### src/dhoa_pkg.sv
// Shared types and constants of the double-hash open-address insert unit.
package dhoa_pkg;

  localparam int unsigned KEY_W       = 31;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned SMOD_W      = 4;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned PROBE_W     = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned TABLE_DEPTH = 32;

  // The dividend is padded to an even width; the divider retires two bits a cycle.
  localparam int unsigned DVD_W     = KEY_W + 1;
  localparam int unsigned MOD_STEPS = DVD_W / 2;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd11;
  localparam logic [SMOD_W-1:0] SMOD_RESET = 4'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODULUS = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_HOME,
    S_MOD_STEP,
    S_REDUCE,
    S_PROBE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] remainder;
  } mod_rsp_t;

endpackage

### src/dhoa_mod_unit.sv
// Shared iterative remainder unit, restoring division two bits per cycle.
module dhoa_mod_unit
  import dhoa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [SIZE_W-1:0]    div_q, div_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;

  logic [SIZE_W:0] t1, t2;
  logic [SIZE_W-1:0] r1, r2;

  always_comb begin
    t1 = {rem_q, dvd_q[DVD_W-1]};
    if (t1 >= {1'b0, div_q}) begin
      t1 = t1 - {1'b0, div_q};
    end
    r1 = t1[SIZE_W-1:0];
    t2 = {r1, dvd_q[DVD_W-2]};
    if (t2 >= {1'b0, div_q}) begin
      t2 = t2 - {1'b0, div_q};
    end
    r2 = t2[SIZE_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (busy_q) begin
      rem_d = r2;
      dvd_d = {dvd_q[DVD_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = {1'b0, req_i.dividend};
      div_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

### src/dhoa_slot_table.sv
// Slot storage: occupancy flags in flip-flops and the key memory.
module dhoa_slot_table
  import dhoa_pkg::*;
#(
  parameter int unsigned USED  = 32,
  parameter int unsigned IDX_W = $clog2(USED)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic             rd_valid_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  logic [KEY_W-1:0] wr_key_i
);

  logic [USED-1:0]  valid_q;
  logic [KEY_W-1:0] keys_mem [USED];

  assign rd_valid_o = valid_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      keys_mem[wr_idx_i] <= wr_key_i;
    end
  end

endmodule

### src/double_hash_open_address_insert_unit.sv
// Top level of the double-hash open-address insert unit.
//
// Usage: drive key_i and raise start_i; the item is taken at a clock edge where
// start_i is high and busy_o is low. busy_o stays high until the insert ends.
// The result (slot_o, table_full_o, probe_count_o) is shown for exactly one
// cycle with done_o high; the receiver cannot stall it, so it must be captured
// then. A new item may be started in the cycle done_o is shown.
// From acceptance to done_o the unit runs two remainder computations on the
// shared divider, at two bits per cycle over the 31-bit key padded to 32 bits,
// a reduction of the step below the table size by repeated subtraction, one
// subtraction at a time, and probes of the occupancy flags, one per cycle, up
// to the effective table size. One item is in flight at a time.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle:
// index 0 is table_size, index 1 is step_modulus; other indices are ignored.
// Reset clears all occupancy flags at once, sets table_size to 11 and
// step_modulus to 2, and leaves the key memory undefined.
module double_hash_open_address_insert_unit
  import dhoa_pkg::*;
#(
  parameter int unsigned TableDepth = TABLE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [KEY_W-1:0]      key_i,
  output logic                  done_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic                  table_full_o,
  output logic [PROBE_W-1:0]    probe_count_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // The size register cannot exceed 63, so no slot beyond that is ever touched.
  localparam int unsigned SizeMax = (1 << SIZE_W) - 1;
  localparam int unsigned Used    = (TableDepth < SizeMax) ? TableDepth : SizeMax;
  localparam int unsigned IdxW    = $clog2(Used);

  state_e state_q, state_d;

  logic [SIZE_W-1:0]  cfg_size_q;
  logic [SMOD_W-1:0]  cfg_smod_q;
  logic [SIZE_W-1:0]  size_eff;
  logic [SIZE_W-1:0]  smod_eff;

  logic [KEY_W-1:0]   key_q, key_d;
  logic [IdxW-1:0]    pos_q, pos_d;
  logic [SIZE_W-1:0]  step_q, step_d;
  logic [PROBE_W-1:0] probes_q, probes_d;

  logic               done_q, done_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               full_q, full_d;
  logic [PROBE_W-1:0] pcnt_q, pcnt_d;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic            slot_busy;
  logic            wr_en;
  logic [SIZE_W:0] pos_sum;
  logic [IdxW-1:0] pos_next;
  logic            last_probe;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= SIZE_RESET;
      cfg_smod_q <= SMOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TABLE_SIZE:   cfg_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_STEP_MODULUS: cfg_smod_q <= cfg_data_i[SMOD_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    size_eff = cfg_size_q;
    if (cfg_size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (cfg_size_q > SIZE_W'(Used)) begin
      size_eff = SIZE_W'(Used);
    end
    smod_eff = (cfg_smod_q == '0) ? SIZE_W'(1) : SIZE_W'(cfg_smod_q);
  end

  dhoa_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  dhoa_slot_table #(
    .USED  (Used),
    .IDX_W (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (pos_q),
    .rd_valid_o (slot_busy),
    .wr_en_i    (wr_en),
    .wr_idx_i   (pos_q),
    .wr_key_i   (key_q)
  );

  // The step is already below the size, so one subtraction completes the wrap.
  always_comb begin
    pos_sum = (SIZE_W + 1)'(pos_q) + (SIZE_W + 1)'(step_q);
    if (pos_sum >= (SIZE_W + 1)'(size_eff)) begin
      pos_sum = pos_sum - (SIZE_W + 1)'(size_eff);
    end
    pos_next   = pos_sum[IdxW-1:0];
    last_probe = ((probes_q + 1'b1) == PROBE_W'(size_eff));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (start_i) state_d = S_MOD_HOME;
      S_MOD_HOME: if (mod_rsp.done) state_d = S_MOD_STEP;
      S_MOD_STEP: if (mod_rsp.done) state_d = S_REDUCE;
      S_REDUCE:   if (step_q < size_eff) state_d = S_PROBE;
      S_PROBE:    if (!slot_busy || last_probe) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    key_d    = key_q;
    pos_d    = pos_q;
    step_d   = step_q;
    probes_d = probes_q;
    done_d   = 1'b0;
    slot_d   = slot_q;
    full_d   = full_q;
    pcnt_d   = pcnt_q;
    wr_en    = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = key_q;
    mod_req.divisor  = size_eff;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d            = key_i;
          mod_req.start    = 1'b1;
          mod_req.dividend = key_i;
        end
      end
      S_MOD_HOME: begin
        if (mod_rsp.done) begin
          pos_d           = mod_rsp.remainder[IdxW-1:0];
          mod_req.start   = 1'b1;
          mod_req.divisor = smod_eff;
        end
      end
      S_MOD_STEP: begin
        if (mod_rsp.done) begin
          step_d   = mod_rsp.remainder + 1'b1;
          probes_d = '0;
        end
      end
      S_REDUCE: begin
        if (step_q >= size_eff) begin
          step_d = step_q - size_eff;
        end
      end
      S_PROBE: begin
        probes_d = probes_q + 1'b1;
        if (!slot_busy) begin
          wr_en  = 1'b1;
          done_d = 1'b1;
          slot_d = SLOT_W'(pos_q);
          full_d = 1'b0;
          pcnt_d = probes_q + 1'b1;
        end else if (last_probe) begin
          done_d = 1'b1;
          slot_d = '0;
          full_d = 1'b1;
          pcnt_d = probes_q + 1'b1;
        end else begin
          pos_d = pos_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    pos_q    <= pos_d;
    step_q   <= step_d;
    probes_q <= probes_d;
    slot_q   <= slot_d;
    full_q   <= full_d;
    pcnt_q   <= pcnt_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign slot_o        = slot_q;
  assign table_full_o  = full_q;
  assign probe_count_o = pcnt_q;

  // A result only follows the last probe of an insert.
  a_done_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_PROBE))
    else $error("result strobe without a preceding probe");

  // An accepted item keeps the unit busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted but unit not busy");

  // A full result reports slot zero and a probe count equal to the effective table size.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (slot_o == '0 && probe_count_o == PROBE_W'(size_eff)))
    else $error("full result with wrong slot or probe count");

  // The probe counter never passes the table size during a search.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (probes_q < PROBE_W'(size_eff)))
    else $error("probe count exceeded table size");

endmodule

### tb/sv/double_hash_open_address_insert_unit_checker.sv
// Checker that predicts and compares every insert result of the double-hash unit.
`timescale 1ns / 100ps
module double_hash_open_address_insert_unit_checker
  import dhoa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [KEY_W-1:0]      key_i,
  input  logic                  done_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic                  table_full_i,
  input  logic [PROBE_W-1:0]    probe_count_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               full;
    logic [PROBE_W-1:0] probes;
  } insert_result_t;

  logic [SIZE_W-1:0]      table_size_q   = SIZE_RESET;
  logic [SMOD_W-1:0]      step_modulus_q = SMOD_RESET;
  logic [TABLE_DEPTH-1:0] slot_taken     = '0;
  insert_result_t         insert_results_q[$];
  int unsigned            mismatch_count = 0;
  int unsigned            pending_count  = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Walks the probe sequence over the occupancy flags and claims the first free slot.
  function automatic insert_result_t predict_insert(input logic [KEY_W-1:0] key);
    int unsigned    size;
    int unsigned    modulus;
    int unsigned    step;
    int unsigned    pos;
    int unsigned    probes;
    bit             found;
    insert_result_t res;
    size = (table_size_q == '0) ? 1 : table_size_q;
    if (size > TABLE_DEPTH) size = TABLE_DEPTH;
    modulus = (step_modulus_q == '0) ? 1 : step_modulus_q;
    step    = (key % modulus) + 1;
    pos     = key % size;
    probes  = 0;
    found   = 1'b0;
    while (!found && probes < size) begin
      probes++;
      if (!slot_taken[pos]) found = 1'b1;
      else pos = (pos + step) % size;
    end
    if (found) begin
      slot_taken[pos] = 1'b1;
      res.slot = pos[SLOT_W-1:0];
      res.full = 1'b0;
    end else begin
      res.slot = '0;
      res.full = 1'b1;
    end
    res.probes = probes[PROBE_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    insert_result_t want;
    if (!rst_ni) begin
      table_size_q   = SIZE_RESET;
      step_modulus_q = SMOD_RESET;
      slot_taken     = '0;
      insert_results_q.delete();
      pending_count  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TABLE_SIZE) table_size_q = cfg_data_i[SIZE_W-1:0];
        else if (cfg_idx_i == REG_STEP_MODULUS) step_modulus_q = cfg_data_i[SMOD_W-1:0];
      end
      // The result of the previous item is retired before a new item in the same cycle.
      if (done_i) begin
        if (insert_results_q.size() == 0) begin
          report_mismatch($sformatf("result slot %0d full %0b probes %0d with no insert pending",
                                    slot_i, table_full_i, probe_count_i));
        end else begin
          want = insert_results_q.pop_front();
          if (slot_i !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", slot_i, want.slot));
          if (table_full_i !== want.full)
            report_mismatch($sformatf("table_full %0b, expected %0b", table_full_i, want.full));
          if (probe_count_i !== want.probes)
            report_mismatch($sformatf("probe_count %0d, expected %0d",
                                      probe_count_i, want.probes));
        end
      end
      if (start_i && !busy_i) insert_results_q.push_back(predict_insert(key_i));
      pending_count = insert_results_q.size();
    end
  end

endmodule

### tb/sv/double_hash_open_address_insert_unit_test.sv
// Stimulus and verdict for the double-hash open-address insert unit.
`timescale 1ns / 100ps
module double_hash_open_address_insert_unit_test;
  import dhoa_pkg::*;

  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RAND_PHASES    = 36;
  localparam int unsigned KEYS_PER_PHASE = 25;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [KEY_W-1:0]     KEY_MAX     = '1;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start_i    = 1'b0;
  logic                  busy_o;
  logic [KEY_W-1:0]      key_i      = '0;
  logic                  done_o;
  logic [SLOT_W-1:0]     slot_o;
  logic                  table_full_o;
  logic [PROBE_W-1:0]    probe_count_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_pct     = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  double_hash_open_address_insert_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .key_i         (key_i),
    .done_o        (done_o),
    .slot_o        (slot_o),
    .table_full_o  (table_full_o),
    .probe_count_o (probe_count_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  double_hash_open_address_insert_unit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .key_i         (key_i),
    .done_i        (done_o),
    .slot_i        (slot_o),
    .table_full_i  (table_full_o),
    .probe_count_i (probe_count_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  // A run that stops taking items or returning results is a failure.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("double_hash_open_address_insert_unit: mismatch");
      $finish;
    end
  end

  // Called at a falling edge; start_i returns low between items.
  task automatic send_key(input logic [KEY_W-1:0] key);
    bit taken;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start_i <= 1'b1;
    key_i   <= key;
    taken = 1'b0;
    // busy_o only moves after a rising edge, so its value here holds for the next edge.
    while (!taken) begin
      taken = !busy_o;
      @(negedge clk_i);
    end
    start_i <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_count != 0 || busy_o) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      item;
    int unsigned      size;
    logic [KEY_W-1:0] key;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: collisions around the home slot, the smallest and widest keys.
    send_key('0);
    send_key(KEY_MAX);
    send_key(31'd11);
    send_key(31'd22);
    send_key(31'd33);
    send_key(31'd7);
    wait_drain();

    // A zero size behaves as one slot and a zero modulus gives a step of one.
    write_reg(REG_TABLE_SIZE, 6'd0);
    write_reg(REG_STEP_MODULUS, 6'd0);
    send_key(31'd5);
    send_key(KEY_MAX);
    wait_drain();

    // Oversized tables saturate at the full depth; spare indices change nothing.
    write_reg(REG_TABLE_SIZE, 6'd63);
    write_reg(REG_STEP_MODULUS, 6'd15);
    write_reg(REG_SPARE_2, 6'd1);
    write_reg(REG_SPARE_3, 6'd2);
    send_key(KEY_MAX);
    send_key(31'h2AAA_AAAA);
    send_key(31'h5555_5555);
    send_key(31'd32);
    send_key(31'd63);
    wait_drain();

    // A step equal to the size revisits one slot, so the insert fails with free slots left.
    write_reg(REG_TABLE_SIZE, 6'd4);
    write_reg(REG_STEP_MODULUS, 6'd8);
    send_key(31'd3);
    send_key(31'd19);
    wait_drain();

    write_reg(REG_TABLE_SIZE, 6'd1);
    write_reg(REG_STEP_MODULUS, 6'd1);
    send_key(KEY_MAX);
    wait_drain();

    write_reg(REG_TABLE_SIZE, 6'd2);
    write_reg(REG_STEP_MODULUS, 6'd8);
    send_key(31'd1);
    send_key(31'd2);

    // Occupancy is only cleared by reset, so the size mostly grows to open fresh slots.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_drain();
      size = 2 + (phase * 31) / (RAND_PHASES - 1);
      if (phase % 9 == 4) begin
        case ($urandom_range(4))
          0:       size = 0;
          1:       size = 1;
          2:       size = 32;
          3:       size = 33;
          default: size = 63;
        endcase
      end
      write_reg(REG_TABLE_SIZE, size[CFG_DATA_W-1:0]);
      write_reg(REG_STEP_MODULUS, CFG_DATA_W'($urandom_range(63)));
      if (phase % 5 == 2)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom_range(63)));
      case (phase % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 58;
        2:       idle_pct = 0;
        default: idle_pct = 25;
      endcase
      for (item = 0; item < KEYS_PER_PHASE; item++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: key = KEY_W'($urandom);
          5, 6, 7:       key = KEY_W'($urandom_range(255));
          default:       key = KEY_MAX - KEY_W'($urandom_range(255));
        endcase
        send_key(key);
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("double_hash_open_address_insert_unit: match");
    end else begin
      $display("double_hash_open_address_insert_unit: mismatch");
    end
    $finish;
  end

endmodule
